/* design/rsiw_pkg.sv */
// Package for the relative strength index window block.
// Holds widths, constants, payload structs and the divider state type.
// No dependencies; used by rsiw_div and relative_strength_index_window.
package rsiw_pkg;

    localparam int PRICE_BITS = 32;
    localparam int SUM_BITS   = 40;
    localparam int RSI_BITS   = 14;
    localparam int CFG_BITS   = 8;
    localparam int PROD_BITS  = SUM_BITS + RSI_BITS;
    localparam int STEP_BITS  = $clog2(RSI_BITS);

    localparam logic [CFG_BITS-1:0] MAX_WINDOW = 8'd255;
    localparam logic [CFG_BITS-1:0] WL_RESET   = 8'd14;
    localparam logic [RSI_BITS-1:0] RSI_SCALE  = 14'd10000;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic                  restart;
    } t_in;

    typedef struct packed {
        logic [RSI_BITS-1:0] rsi_hundredths;
        logic [SUM_BITS-1:0] gain_total;
        logic [SUM_BITS-1:0] loss_total;
        logic                no_movement;
    } t_out;

    typedef struct packed {
        logic [SUM_BITS-1:0] gain;
        logic [SUM_BITS-1:0] loss;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_div_state;

endpackage

/* design/rsiw_div.sv */
// Index unit: scales the gain total by 10000 with a bit-serial shift-add,
// then forms gain*10000/(gain+loss) with a restoring divider, one bit a cycle.
// Depends on rsiw_pkg.
module rsiw_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  rsiw_pkg::t_job i_job,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output rsiw_pkg::t_out o_res
);

    rsiw_pkg::t_div_state r_state, n_state;

    logic [rsiw_pkg::SUM_BITS:0]    r_total;
    logic [rsiw_pkg::SUM_BITS-1:0]  r_gain;
    logic [rsiw_pkg::SUM_BITS-1:0]  r_loss;
    logic                           r_zero;
    logic [rsiw_pkg::PROD_BITS-1:0] r_mcand;
    logic [rsiw_pkg::RSI_BITS-1:0]  r_mult;
    logic [rsiw_pkg::PROD_BITS-1:0] r_prod;
    logic [rsiw_pkg::SUM_BITS:0]    r_rem;
    logic [rsiw_pkg::RSI_BITS-1:0]  r_qd;
    logic [rsiw_pkg::STEP_BITS-1:0] r_step;

    logic [rsiw_pkg::PROD_BITS-1:0] n_prod;
    logic [rsiw_pkg::SUM_BITS+1:0]  w_rem2;
    logic                           w_ge;

    assign n_prod = r_mult[0] ? (r_prod + r_mcand) : r_prod;
    assign w_rem2 = {r_rem, r_qd[rsiw_pkg::RSI_BITS-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_total});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsiw_pkg::S_IDLE: begin
                if (i_job_valid) n_state = rsiw_pkg::S_MUL;
            end
            rsiw_pkg::S_MUL: begin
                if (r_step == '0) n_state = rsiw_pkg::S_DIV;
            end
            rsiw_pkg::S_DIV: begin
                if (r_step == '0) n_state = rsiw_pkg::S_DONE;
            end
            rsiw_pkg::S_DONE: begin
                if (i_res_ready) n_state = rsiw_pkg::S_IDLE;
            end
            default: n_state = rsiw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsiw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rsiw_pkg::S_IDLE: begin
                r_gain  <= i_job.gain;
                r_loss  <= i_job.loss;
                r_total <= {1'b0, i_job.gain} + {1'b0, i_job.loss};
                r_zero  <= (i_job.gain == '0) && (i_job.loss == '0);
                r_mcand <= rsiw_pkg::PROD_BITS'(i_job.gain);
                r_mult  <= rsiw_pkg::RSI_SCALE;
                r_prod  <= '0;
                r_step  <= rsiw_pkg::STEP_BITS'(rsiw_pkg::RSI_BITS - 1);
            end
            rsiw_pkg::S_MUL: begin
                // one multiplier bit per cycle
                r_prod  <= n_prod;
                r_mcand <= {r_mcand[rsiw_pkg::PROD_BITS-2:0], 1'b0};
                r_mult  <= {1'b0, r_mult[rsiw_pkg::RSI_BITS-1:1]};
                if (r_step == '0) begin
                    // quotient fits RSI_BITS, so the high part is already below the total
                    r_rem  <= {1'b0, n_prod[rsiw_pkg::PROD_BITS-1:rsiw_pkg::RSI_BITS]};
                    r_qd   <= n_prod[rsiw_pkg::RSI_BITS-1:0];
                    r_step <= rsiw_pkg::STEP_BITS'(rsiw_pkg::RSI_BITS - 1);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            rsiw_pkg::S_DIV: begin
                // shift the next dividend bit out, the quotient bit in
                r_rem  <= w_ge ? (w_rem2[rsiw_pkg::SUM_BITS:0] - r_total)
                               : w_rem2[rsiw_pkg::SUM_BITS:0];
                r_qd   <= {r_qd[rsiw_pkg::RSI_BITS-2:0], w_ge};
                r_step <= r_step - 1'b1;
            end
            rsiw_pkg::S_DONE: begin
                r_step <= r_step;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_job_ready = (r_state == rsiw_pkg::S_IDLE);
    assign o_res_valid = (r_state == rsiw_pkg::S_DONE);

    always_comb begin
        o_res.rsi_hundredths = r_zero ? '0 : r_qd;
        o_res.gain_total     = r_gain;
        o_res.loss_total     = r_loss;
        o_res.no_movement    = r_zero;
    end

`ifndef SYNTH
    a_start_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && o_job_ready) |=> (r_state == rsiw_pkg::S_MUL))
        else $error("divider did not start after taking a job");

    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rsiw_pkg::S_DIV) && !r_zero) |-> (r_rem < r_total))
        else $error("partial remainder reached the divisor");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.rsi_hundredths <= rsiw_pkg::RSI_SCALE))
        else $error("index above full scale");
`endif

endmodule

/* design/relative_strength_index_window.sv */
// Top level of the relative strength index window block.
// Accumulates gain and loss per price move and hands finished windows to rsiw_div.
// Depends on rsiw_pkg and rsiw_div.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------
//  in      | i_in_valid / o_in_ready  | i_in_data  (rsiw_pkg::t_in)
//  out     | o_out_valid / i_out_ready| o_out_data (rsiw_pkg::t_out)
//  cfg     | i_cfg_we                 | i_cfg_data (window_length)
//
// A price request is compared in the accept cycle and added next, saturating; no new
// request is taken before the add. The price that closes a window also posts the job
// to the unit, and input waits until the unit has taken it. A window end occupies
// the index unit for 14 shift-add steps, 14 divide steps, load and hand-off; prices
// keep flowing until a second window end has to wait for the unit. Synchronous
// active-low reset restores window_length 14 and forgets the reference price.
module relative_strength_index_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rsiw_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rsiw_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [rsiw_pkg::CFG_BITS-1:0] i_cfg_data
);

    logic [rsiw_pkg::CFG_BITS-1:0]   r_wl;
    logic [rsiw_pkg::PRICE_BITS-1:0] r_ref;
    logic                            r_have_ref;
    logic [rsiw_pkg::SUM_BITS-1:0]   r_gain;
    logic [rsiw_pkg::SUM_BITS-1:0]   r_loss;
    logic [rsiw_pkg::CFG_BITS-1:0]   r_move_count;

    logic                            r_stg;
    logic                            r_stg_start;
    logic                            r_stg_up;
    logic                            r_stg_dn;
    logic [rsiw_pkg::PRICE_BITS-1:0] r_stg_diff;

    logic                            r_job_valid;
    rsiw_pkg::t_job                  r_job;
    logic                            w_job_ready;

    logic                            w_in_fire;
    logic [rsiw_pkg::PRICE_BITS-1:0] w_price;
    logic [rsiw_pkg::CFG_BITS-1:0]   w_eff;
    logic [rsiw_pkg::CFG_BITS-1:0]   n_move_count;
    logic [rsiw_pkg::SUM_BITS:0]     w_gain_add;
    logic [rsiw_pkg::SUM_BITS:0]     w_loss_add;
    logic [rsiw_pkg::SUM_BITS-1:0]   n_gain;
    logic [rsiw_pkg::SUM_BITS-1:0]   n_loss;
    logic                            w_window_end;

    assign o_in_ready = !r_stg && !r_job_valid;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_price    = i_in_data.price;

    always_comb begin
        if (r_wl == '0) begin
            w_eff = rsiw_pkg::CFG_BITS'(1);
        end else if (r_wl > rsiw_pkg::MAX_WINDOW) begin
            w_eff = rsiw_pkg::MAX_WINDOW;
        end else begin
            w_eff = r_wl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= rsiw_pkg::WL_RESET;
        end else if (i_cfg_we) begin
            r_wl <= i_cfg_data;
        end
    end

    // accept cycle: compare against the reference and register the move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg      <= 1'b0;
            r_have_ref <= 1'b0;
            r_ref      <= '0;
        end else begin
            r_stg <= w_in_fire;
            if (w_in_fire) begin
                r_have_ref <= 1'b1;
                r_ref      <= w_price;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_stg_start <= i_in_data.restart || !r_have_ref;
            r_stg_up    <= (w_price > r_ref);
            r_stg_dn    <= (w_price < r_ref);
            r_stg_diff  <= (w_price > r_ref) ? (w_price - r_ref) : (r_ref - w_price);
        end
    end

    assign w_gain_add   = {1'b0, r_gain} + (rsiw_pkg::SUM_BITS + 1)'(r_stg_diff);
    assign w_loss_add   = {1'b0, r_loss} + (rsiw_pkg::SUM_BITS + 1)'(r_stg_diff);
    assign n_gain       = !r_stg_up ? r_gain
                        : (w_gain_add[rsiw_pkg::SUM_BITS] ? '1
                                                          : w_gain_add[rsiw_pkg::SUM_BITS-1:0]);
    assign n_loss       = !r_stg_dn ? r_loss
                        : (w_loss_add[rsiw_pkg::SUM_BITS] ? '1
                                                          : w_loss_add[rsiw_pkg::SUM_BITS-1:0]);
    assign n_move_count = r_move_count + 1'b1;
    assign w_window_end = r_stg && !r_stg_start && (n_move_count >= w_eff);

    // second cycle: saturating accumulate, close the window when the count is reached
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= '0;
            r_loss       <= '0;
            r_move_count <= '0;
            r_job_valid  <= 1'b0;
        end else begin
            if (r_stg) begin
                if (r_stg_start || w_window_end) begin
                    r_gain       <= '0;
                    r_loss       <= '0;
                    r_move_count <= '0;
                end else begin
                    r_gain       <= n_gain;
                    r_loss       <= n_loss;
                    r_move_count <= n_move_count;
                end
            end
            if (w_window_end) begin
                r_job_valid <= 1'b1;
            end else if (w_job_ready) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_window_end) begin
            r_job.gain <= n_gain;
            r_job.loss <= n_loss;
        end
    end

    rsiw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (r_job),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (o_out_data)
    );

`ifndef SYNTH
    a_one_per_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_in_ready)
        else $error("price request accepted while the previous one is in flight");

    a_window_to_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_window_end |=> (r_job_valid && (r_move_count == '0)))
        else $error("window end did not post a job and clear the count");

    a_job_has_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> r_have_ref)
        else $error("window closed without a reference price");
`endif

endmodule
